### hw/rtl/soso_pkg.sv
// Package for the slice order sorter.
// Holds the field widths, the command codes and the register map.
// No dependencies.
package soso_pkg;

  localparam int TAG_W  = 16;
  localparam int IDX_W  = 16;
  localparam int NORM_W = 16;
  localparam int POS_W  = 24;
  localparam int KEY_W  = 40;
  localparam int PROD_W = NORM_W + POS_W;
  localparam int SUM_W  = KEY_W + 2;
  localparam int RANK_W = 8;
  localparam int TOL_W  = 16;

  localparam logic signed [SUM_W-1:0] KEY_MAX = SUM_W'((64'sd1 <<< (KEY_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] KEY_MIN = -KEY_MAX - SUM_W'(1);

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_GET   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  // Register indexes on the configuration port.
  localparam logic REG_NORMAL_TOL = 1'b0;
  localparam logic REG_SPAN_TOL   = 1'b1;

  // Insertion request handed to a chain of cells.
  typedef struct packed {
    logic             ins;
    logic [TAG_W-1:0] tag;
  } ins_req_t;

endpackage

### hw/rtl/soso_cell.sv
// One cell of a sorted insertion chain: holds one tag and its key.
// Depends on soso_pkg.
module soso_cell #(
  parameter int KEY_BITS   = 40,
  parameter bit SIGNED_KEY = 1'b1
) (
  input  logic                       clk,
  input  soso_pkg::ins_req_t         req,
  input  logic [KEY_BITS-1:0]        new_key,
  input  logic                       occ,
  input  logic                       at_end,
  input  logic [soso_pkg::TAG_W-1:0] left_tag,
  input  logic [KEY_BITS-1:0]        left_key,
  input  logic                       left_gt,
  output logic [soso_pkg::TAG_W-1:0] tag,
  output logic [KEY_BITS-1:0]        key,
  output logic                       gt
);
  import soso_pkg::*;

  logic [TAG_W-1:0]    tag_r;
  logic [KEY_BITS-1:0] key_r;
  logic                greater;
  logic                take;

  // Strictly greater keeps equal keys ahead, so ties stay in arrival order.
  always_comb begin
    if (SIGNED_KEY) begin
      greater = $signed(key_r) > $signed(new_key);
    end else begin
      greater = key_r > new_key;
    end
  end

  assign gt   = occ && greater;
  assign take = req.ins && (gt || at_end);

  // A moving cell takes its left neighbor's entry, or the new one at the gap.
  always_ff @(posedge clk) begin
    if (take) begin
      tag_r <= left_gt ? left_tag : req.tag;
      key_r <= left_gt ? left_key : new_key;
    end
  end

  assign tag = tag_r;
  assign key = key_r;

endmodule

### hw/rtl/soso_chain.sv
// Row of insertion cells forming one sorted list, with rank and tail readout.
// Depends on soso_pkg and soso_cell.
module soso_chain #(
  parameter int N          = 256,
  parameter int KEY_BITS   = 40,
  parameter bit SIGNED_KEY = 1'b1,
  parameter int CW         = $clog2(N + 1)
) (
  input  logic                         clk,
  input  soso_pkg::ins_req_t           req,
  input  logic [KEY_BITS-1:0]          new_key,
  input  logic [CW-1:0]                count,
  input  logic [soso_pkg::RANK_W-1:0]  rank,
  output logic [soso_pkg::TAG_W-1:0]   rd_tag,
  output logic [KEY_BITS-1:0]          first_key,
  output logic [KEY_BITS-1:0]          last_key
);
  import soso_pkg::*;

  localparam int RW = (CW > RANK_W) ? CW : RANK_W;

  logic [TAG_W-1:0]    tags [N];
  logic [KEY_BITS-1:0] keys [N];
  logic [N-1:0]        gts;
  logic [N-1:0]        hit;
  logic [N-1:0]        tail;
  logic [RW-1:0]       rank_w;
  logic [CW-1:0]       last_idx;

  assign rank_w   = RW'(rank);
  assign last_idx = count - CW'(1);

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [TAG_W-1:0]    l_tag;
    logic [KEY_BITS-1:0] l_key;
    logic                l_gt;
    if (i == 0) begin : g_head
      assign l_tag = '0;
      assign l_key = '0;
      assign l_gt  = 1'b0;
    end else begin : g_body
      assign l_tag = tags[i-1];
      assign l_key = keys[i-1];
      assign l_gt  = gts[i-1];
    end
    soso_cell #(.KEY_BITS(KEY_BITS), .SIGNED_KEY(SIGNED_KEY)) u_cell (
      .clk      (clk),
      .req      (req),
      .new_key  (new_key),
      .occ      (CW'(i) < count),
      .at_end   (CW'(i) == count),
      .left_tag (l_tag),
      .left_key (l_key),
      .left_gt  (l_gt),
      .tag      (tags[i]),
      .key      (keys[i]),
      .gt       (gts[i])
    );
    assign hit[i]  = (RW'(i) == rank_w);
    assign tail[i] = (CW'(i) == last_idx);
  end

  // One-hot readout of the cell at the rank and of the last occupied cell.
  always_comb begin
    rd_tag   = '0;
    last_key = '0;
    for (int i = 0; i < N; i++) begin
      rd_tag   = rd_tag | (tags[i] & {TAG_W{hit[i]}});
      last_key = last_key | (keys[i] & {KEY_BITS{tail[i]}});
    end
  end

  assign first_key = keys[0];

endmodule

### hw/rtl/slice_order_sorter.sv
// Slice order sorter: an add that stays in volume mode passes accept, multiply, sum and
// insert, any other add ends at accept; a get passes accept, a span test (only in volume mode
// with a non-empty distance list) and select, and its result holds off input until taken.
// A clear ends at accept. One item is in work at a time: input is taken only when idle with no result pending.
// Reset (rst_n low, synchronous) empties both lists, sets volume mode and
// zeroes the reference normal and both tolerance registers.
module slice_order_sorter #(
  parameter int MAX_SLICES = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: slice_tag, has_index, series_index, has_position, normal_x,
  // normal_y, normal_z, pos_x, pos_y, pos_z, rank, zero pad to 168 bits
  input  logic [167:0] in_tdata,
  // tuser: mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: tag_out
  output logic [15:0]  out_tdata,
  // tuser: volume_order, out_of_range
  output logic [1:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import soso_pkg::*;

  localparam int CW = $clog2(MAX_SLICES + 1);
  localparam int RW = (CW > RANK_W) ? CW : RANK_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_INS, S_SPAN, S_SEL
  } state_t;

  state_t state_r;

  logic [TOL_W-1:0]         normal_tol_r, span_tol_r;
  logic signed [NORM_W-1:0] ref_normal_r [3];
  logic                     still_volume_r;
  logic [CW-1:0]            dcount_r, icount_r;
  logic [TAG_W-1:0]         tag_r;
  logic signed [POS_W-1:0]  pos_r [3];
  logic signed [PROD_W-1:0] prod_r [3];
  logic [KEY_W-1:0]         key_r;
  logic [KEY_W-1:0]         last_key_r;
  logic [RANK_W-1:0]        rank_r;
  logic                     out_valid_r;
  logic [TAG_W-1:0]         out_tag_r;
  logic [1:0]               out_user_r;

  // Input field unpacking.
  logic [1:0]               f_mode;
  logic [TAG_W-1:0]         f_tag;
  logic                     f_has_index, f_has_pos;
  logic [IDX_W-1:0]         f_index;
  logic signed [NORM_W-1:0] f_norm [3];
  logic signed [POS_W-1:0]  f_pos [3];
  logic [RANK_W-1:0]        f_rank;

  assign f_tag       = in_tdata[15:0];
  assign f_has_index = in_tdata[16];
  assign f_index     = in_tdata[32:17];
  assign f_has_pos   = in_tdata[33];
  assign f_norm[0]   = in_tdata[49:34];
  assign f_norm[1]   = in_tdata[65:50];
  assign f_norm[2]   = in_tdata[81:66];
  assign f_pos[0]    = in_tdata[105:82];
  assign f_pos[1]    = in_tdata[129:106];
  assign f_pos[2]    = in_tdata[153:130];
  assign f_rank      = in_tdata[161:154];
  assign f_mode      = in_tuser;

  logic accept;
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign accept    = in_tvalid && in_tready;

  // Per-axis normal difference against the reference.
  logic norm_bad;
  always_comb begin
    logic signed [NORM_W:0] d;
    logic [NORM_W:0]        a;
    norm_bad = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = {ref_normal_r[k][NORM_W-1], ref_normal_r[k]} - {f_norm[k][NORM_W-1], f_norm[k]};
      a = d[NORM_W] ? (NORM_W+1)'(-d) : d;
      if (a > {1'b0, normal_tol_r}) begin
        norm_bad = 1'b1;
      end
    end
  end

  // Sorted lists.
  ins_req_t            dreq, ireq;
  logic [TAG_W-1:0]    d_rd_tag, i_rd_tag;
  logic [KEY_W-1:0]    d_first, d_last;
  logic [IDX_W-1:0]    i_first, i_last;
  logic                d_room, i_room;

  assign d_room   = dcount_r < CW'(MAX_SLICES);
  assign i_room   = icount_r < CW'(MAX_SLICES);
  assign dreq.ins = (state_r == S_INS) && d_room;
  assign dreq.tag = tag_r;
  assign ireq.ins = accept && (f_mode == MODE_ADD) && f_has_index && i_room;
  assign ireq.tag = f_tag;

  soso_chain #(.N(MAX_SLICES), .KEY_BITS(KEY_W), .SIGNED_KEY(1'b1)) u_dist (
    .clk(clk), .req(dreq), .new_key(key_r), .count(dcount_r), .rank(rank_r),
    .rd_tag(d_rd_tag), .first_key(d_first), .last_key(d_last)
  );

  soso_chain #(.N(MAX_SLICES), .KEY_BITS(IDX_W), .SIGNED_KEY(1'b0)) u_index (
    .clk(clk), .req(ireq), .new_key(f_index), .count(icount_r), .rank(rank_r),
    .rd_tag(i_rd_tag), .first_key(i_first), .last_key(i_last)
  );

  // Sum of products with saturation to the key width.
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sat;
  always_comb begin
    sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    if (sum > KEY_MAX) begin
      sat = KEY_MAX;
    end else if (sum < KEY_MIN) begin
      sat = KEY_MIN;
    end else begin
      sat = sum;
    end
  end

  // Span test and rank selection.
  logic signed [KEY_W:0] span;
  logic                  span_small;
  logic [CW-1:0]         sel_count;
  logic                  oor;
  assign span       = $signed({last_key_r[KEY_W-1], last_key_r}) -
                      $signed({d_first[KEY_W-1], d_first});
  assign span_small = span <= $signed({{(KEY_W+1-TOL_W){1'b0}}, span_tol_r});
  assign sel_count  = still_volume_r ? dcount_r : icount_r;
  assign oor        = !(RW'(rank_r) < RW'(sel_count));

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Control state, work registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      normal_tol_r    <= '0;
      span_tol_r      <= '0;
      still_volume_r  <= 1'b1;
      dcount_r        <= '0;
      icount_r        <= '0;
      out_valid_r     <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        ref_normal_r[k] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_NORMAL_TOL: normal_tol_r <= cfg_pwdata[TOL_W-1:0];
          REG_SPAN_TOL:   span_tol_r   <= cfg_pwdata[TOL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            tag_r  <= f_tag;
            rank_r <= f_rank;
            case (f_mode)
              MODE_ADD: begin
                if (ireq.ins) begin
                  icount_r <= icount_r + CW'(1);
                end
                if (still_volume_r) begin
                  if (!f_has_pos || (dcount_r != '0 && norm_bad)) begin
                    still_volume_r <= 1'b0;
                    dcount_r       <= '0;
                  end else begin
                    if (dcount_r == '0) begin
                      for (int k = 0; k < 3; k++) begin
                        ref_normal_r[k] <= f_norm[k];
                      end
                    end
                    for (int k = 0; k < 3; k++) begin
                      pos_r[k] <= f_pos[k];
                    end
                    state_r <= S_MUL;
                  end
                end
              end
              MODE_GET: begin
                last_key_r <= d_last;
                if (still_volume_r && dcount_r != '0) begin
                  state_r <= S_SPAN;
                end else begin
                  state_r <= S_SEL;
                end
              end
              MODE_CLEAR: begin
                still_volume_r <= 1'b1;
                dcount_r       <= '0;
                icount_r       <= '0;
                for (int k = 0; k < 3; k++) begin
                  ref_normal_r[k] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          for (int k = 0; k < 3; k++) begin
            prod_r[k] <= ref_normal_r[k] * pos_r[k];
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          key_r   <= sat[KEY_W-1:0];
          state_r <= S_INS;
        end
        S_INS: begin
          if (d_room) begin
            dcount_r <= dcount_r + CW'(1);
          end
          state_r <= S_IDLE;
        end
        S_SPAN: begin
          // A small span leaves volume mode until the next clear; the distance list is no longer read.
          if (span_small) begin
            still_volume_r <= 1'b0;
            dcount_r       <= '0;
          end
          state_r <= S_SEL;
        end
        S_SEL: begin
          out_valid_r <= 1'b1;
          out_tag_r   <= oor ? '0 : (still_volume_r ? d_rd_tag : i_rd_tag);
          out_user_r  <= {oor, still_volume_r};
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tag_r;
  assign out_tuser  = out_user_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(cfg_paddr[2] ? span_tol_r : normal_tol_r);

  // The index list keys feed nothing but its own ordering.
  logic unused_keys;
  assign unused_keys = ^{i_first, i_last};

  // Checks on the control state.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result pending while an item is in work");
  a_flat_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !still_volume_r |-> dcount_r == '0)
    else $error("distance list not empty outside volume mode");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    dcount_r <= CW'(MAX_SLICES) && icount_r <= CW'(MAX_SLICES))
    else $error("list count beyond capacity");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[1]) |-> out_tag_r == '0)
    else $error("out of range result carries a tag");

endmodule

### tb/tb.sv
// Self-checking testbench for the slice order sorter.
// Drives add, get, clear and unused-mode items on the input stream, predicts every get answer
// with its own model of both sorted lists, and checks the result stream. Needs soso_pkg.
module tb;
  import soso_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 12;
  localparam int DEPTH = 256;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] tag;
    logic        has_index;
    logic [15:0] series_index;
    logic        has_position;
    logic [15:0] nrm [3];
    logic [23:0] pos [3];
    logic [7:0]  rank;
  } slice_item_t;

  typedef struct {
    logic [15:0] tag;
    logic        volume;
    logic        out_of_range;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [15:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  slice_order_sorter dut (.*);

  // Predictor state: both sorted lists, reference normal and tolerances.
  logic [15:0] dist_tag [DEPTH];
  longint      dist_key [DEPTH];
  int          dist_cnt;
  logic [15:0] idx_tag [DEPTH];
  logic [15:0] idx_key [DEPTH];
  int          idx_cnt;
  int          ref_nrm [3];
  bit          in_volume;
  int          norm_tol;
  int          span_tol;

  answer_t     pending_answers [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;
  int          base_nrm [3];

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("slice_order_sorter: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random unless idling is switched off.
  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
  end

  // Compare each accepted result with the oldest expected answer.
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result tag_out=%0h", out_tdata);
        fail_count++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (out_tdata !== exp_ans.tag) begin
          $error("tag_out expected %0h actual %0h", exp_ans.tag, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== exp_ans.volume) begin
          $error("volume_order expected %0b actual %0b", exp_ans.volume, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== exp_ans.out_of_range) begin
          $error("out_of_range expected %0b actual %0b", exp_ans.out_of_range, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  function automatic void clear_lists();
    ref_nrm = '{0, 0, 0};
    in_volume = 1'b1;
    dist_cnt = 0;
    idx_cnt = 0;
  endfunction

  function automatic void insert_by_index(logic [15:0] tag, logic [15:0] key);
    int i;
    if (idx_cnt >= DEPTH) return;
    i = idx_cnt;
    while (i > 0 && idx_key[i-1] > key) begin
      idx_key[i] = idx_key[i-1];
      idx_tag[i] = idx_tag[i-1];
      i--;
    end
    idx_key[i] = key;
    idx_tag[i] = tag;
    idx_cnt++;
  endfunction

  function automatic void insert_by_distance(logic [15:0] tag, longint key);
    int i;
    if (dist_cnt >= DEPTH) return;
    i = dist_cnt;
    while (i > 0 && dist_key[i-1] > key) begin
      dist_key[i] = dist_key[i-1];
      dist_tag[i] = dist_tag[i-1];
      i--;
    end
    dist_key[i] = key;
    dist_tag[i] = tag;
    dist_cnt++;
  endfunction

  // Update the predicted lists for one accepted item; a get queues its answer.
  function automatic void predict_order(slice_item_t it);
    int     n [3];
    longint dot;
    int     d;
    answer_t ans;
    bit     mismatch;
    case (it.mode)
      MODE_ADD: begin
        if (it.has_index) insert_by_index(it.tag, it.series_index);
        if (in_volume) begin
          if (!it.has_position) begin
            in_volume = 1'b0;
            dist_cnt = 0;
          end else begin
            mismatch = 1'b0;
            for (int k = 0; k < 3; k++) n[k] = $signed(it.nrm[k]);
            if (dist_cnt == 0) begin
              ref_nrm = n;
            end else begin
              for (int k = 0; k < 3; k++) begin
                d = ref_nrm[k] - n[k];
                if (d < 0) d = -d;
                if (d > norm_tol) mismatch = 1'b1;
              end
            end
            if (mismatch) begin
              in_volume = 1'b0;
              dist_cnt = 0;
            end else begin
              dot = 0;
              for (int k = 0; k < 3; k++)
                dot += longint'(ref_nrm[k]) * longint'($signed(it.pos[k]));
              if (dot > longint'(KEY_MAX)) dot = longint'(KEY_MAX);
              if (dot < longint'(KEY_MIN)) dot = longint'(KEY_MIN);
              insert_by_distance(it.tag, dot);
            end
          end
        end
      end
      MODE_CLEAR: clear_lists();
      MODE_GET: begin
        // The span test drops volume order for the rest of the series.
        if (in_volume && dist_cnt > 0)
          if (dist_key[dist_cnt-1] - dist_key[0] <= longint'(span_tol)) in_volume = 1'b0;
        ans.tag = '0;
        ans.volume = in_volume;
        ans.out_of_range = 1'b0;
        if (in_volume) begin
          if (it.rank < dist_cnt) ans.tag = dist_tag[it.rank];
          else ans.out_of_range = 1'b1;
        end else begin
          if (it.rank < idx_cnt) ans.tag = idx_tag[it.rank];
          else ans.out_of_range = 1'b1;
        end
        pending_answers.insert(pending_answers.size(), ans);
      end
      default: ;
    endcase
  endfunction

  // Send one item, with a random gap first, and predict it once accepted.
  task automatic send_item(slice_item_t it);
    if (!no_idle && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {6'b0, it.rank, it.pos[2], it.pos[1], it.pos[0], it.nrm[2], it.nrm[1],
                  it.nrm[0], it.has_position, it.series_index, it.has_index, it.tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_order(it);
  endtask

  // Lower valid and wait for every expected answer plus the block's latency.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_sel, logic [15:0] value);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= {16'($urandom_range(65535)), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_sel == REG_NORMAL_TOL) norm_tol = int'(value);
    else span_tol = int'(value);
  endtask

  function automatic slice_item_t make_add(logic [15:0] tag, logic hi, logic [15:0] sidx,
                                           logic hp, int nx, int ny, int nz,
                                           int px, int py, int pz);
    slice_item_t it;
    it.mode = MODE_ADD;
    it.tag = tag;
    it.has_index = hi;
    it.series_index = sidx;
    it.has_position = hp;
    it.nrm[0] = 16'(nx); it.nrm[1] = 16'(ny); it.nrm[2] = 16'(nz);
    it.pos[0] = 24'(px); it.pos[1] = 24'(py); it.pos[2] = 24'(pz);
    it.rank = 8'($urandom);
    return it;
  endfunction

  function automatic slice_item_t make_cmd(logic [1:0] mode, logic [7:0] rank);
    slice_item_t it;
    it = make_add(16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom), $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
    it.mode = mode;
    it.rank = rank;
    return it;
  endfunction

  // Field extremes, each special case and all modes.
  task automatic test_directed();
    send_item(make_cmd(MODE_GET, 8'd0));
    send_item(make_add(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, -32768, 32767, -32768,
                       8388607, -8388608, 8388607));
    send_item(make_add(16'h0000, 1'b1, 16'h0000, 1'b1, -32768, 32767, -32768,
                       -8388608, 8388607, -8388608));
    send_item(make_add(16'h1234, 1'b0, 16'h0005, 1'b1, -32768, 32767, -32768, 0, 0, 0));
    send_item(make_cmd(MODE_GET, 8'd0));
    send_item(make_cmd(MODE_GET, 8'd2));
    send_item(make_cmd(MODE_GET, 8'd255));
    send_item(make_cmd(MODE_UNUSED, 8'd0));
    send_item(make_add(16'h0042, 1'b1, 16'h0000, 1'b1, 0, 0, 0, 1, 1, 1));
    send_item(make_cmd(MODE_GET, 8'd1));
    send_item(make_cmd(MODE_CLEAR, 8'd0));
    send_item(make_add(16'h0007, 1'b1, 16'h0009, 1'b1, 16384, 0, 0, 256, 0, 0));
    send_item(make_add(16'h0008, 1'b1, 16'h0003, 1'b0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(MODE_GET, 8'd0));
    send_item(make_cmd(MODE_GET, 8'd1));
    send_item(make_cmd(MODE_GET, 8'd2));
    send_item(make_cmd(MODE_CLEAR, 8'd0));
    // Two equal keys stay in arrival order; a zero span then drops volume order.
    send_item(make_add(16'h0101, 1'b1, 16'h0001, 1'b1, 0, 16384, 0, 0, 512, 0));
    send_item(make_add(16'h0102, 1'b1, 16'h0001, 1'b1, 0, 16384, 0, 0, 512, 0));
    send_item(make_cmd(MODE_GET, 8'd1));
    send_item(make_cmd(MODE_CLEAR, 8'd0));
  endtask

  // Span test with the largest span tolerance.
  task automatic test_span();
    write_reg(REG_SPAN_TOL, 16'hFFFF);
    send_item(make_cmd(MODE_CLEAR, 8'd0));
    send_item(make_add(16'h0201, 1'b1, 16'h0002, 1'b1, 0, 0, 16384, 0, 0, 1));
    send_item(make_add(16'h0202, 1'b1, 16'h0001, 1'b1, 0, 0, 16384, 0, 0, 3));
    send_item(make_cmd(MODE_GET, 8'd0));
    send_item(make_cmd(MODE_GET, 8'd1));
    send_item(make_cmd(MODE_CLEAR, 8'd0));
    write_reg(REG_SPAN_TOL, 16'h0000);
  endtask

  // Overfill both lists; the extra slices must not be recorded.
  task automatic test_full_lists();
    send_item(make_cmd(MODE_CLEAR, 8'd0));
    for (int i = 0; i < DEPTH + 4; i++)
      send_item(make_add(16'($urandom), 1'b1, 16'($urandom_range(300)), 1'b1, 0, 16384, 0,
                         0, $urandom_range(4000), 0));
    for (int i = 0; i < 6; i++)
      send_item(make_cmd(MODE_GET, (i < 3) ? 8'd255 - 8'(i) : 8'($urandom)));
    send_item(make_cmd(MODE_CLEAR, 8'd0));
  endtask

  function automatic int near_normal(int base);
    int v;
    v = base + $urandom_range(2 * (norm_tol > 64 ? 64 : norm_tol) + 2)
        - (norm_tol > 64 ? 64 : norm_tol) - 1;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Mostly well-formed series with random content, plus noise and broken series.
  task automatic test_random(int count);
    slice_item_t it;
    int roll;
    int count_hint;
    for (int k = 0; k < 3; k++) base_nrm[k] = $signed(16'($urandom));
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        it = make_add(16'($urandom), $urandom_range(99) < 85, $urandom_range(99) < 70 ?
                      16'($urandom_range(40)) : 16'($urandom), $urandom_range(99) < 95,
                      near_normal(base_nrm[0]), near_normal(base_nrm[1]),
                      near_normal(base_nrm[2]), $urandom, $urandom, $urandom);
        if ($urandom_range(99) < 40)
          for (int k = 0; k < 3; k++)
            it.pos[k] = 24'($signed(24'($urandom_range(600))) - 300);
        if ($urandom_range(99) < 4)
          for (int k = 0; k < 3; k++) it.nrm[k] = 16'($urandom);
      end else if (roll < 92) begin
        count_hint = in_volume ? dist_cnt : idx_cnt;
        it = make_cmd(MODE_GET, $urandom_range(99) < 80 ? 8'($urandom_range(count_hint + 1))
                                                        : 8'($urandom));
      end else if (roll < 96) begin
        it = make_cmd(MODE_CLEAR, 8'($urandom));
        for (int k = 0; k < 3; k++) base_nrm[k] = $signed(16'($urandom));
      end else begin
        it = make_cmd(MODE_UNUSED, 8'($urandom));
      end
      send_item(it);
      // Hold off once so the block runs dry mid-stream.
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    clear_lists();
    norm_tol = 0;
    span_tol = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_span();
    test_full_lists();
    test_random(130);
    write_reg(REG_NORMAL_TOL, 16'hFFFF);
    write_reg(REG_SPAN_TOL, 16'hFFFF);
    test_random(130);
    write_reg(REG_NORMAL_TOL, 16'($urandom_range(40)));
    write_reg(REG_SPAN_TOL, 16'($urandom_range(65535)));
    no_idle = 1'b1;
    test_random(130);
    no_idle = 1'b0;
    write_reg(REG_NORMAL_TOL, 16'($urandom));
    write_reg(REG_SPAN_TOL, 16'($urandom_range(300)));
    test_random(130);
    wait_drained();
    if (fail_count == 0) begin
      $display("slice_order_sorter: match");
    end else begin
      $display("slice_order_sorter: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/soso_pkg.sv
hw/rtl/soso_cell.sv
hw/rtl/soso_chain.sv
hw/rtl/slice_order_sorter.sv
tb/tb.sv
